FILE: design/ego_pkg.sv
package ego_pkg;

   // Default number of CORDIC micro-rotations.
   localparam int CORDIC_ITERATIONS_DEFAULT = 24;

   // Configuration port index width and register indexes.
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_X = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_Y = CSR_INDEX_W'(1);

   // Shared multiplier operand and product widths.
   localparam int MUL_OP_W   = 33;
   localparam int MUL_PROD_W = 2 * MUL_OP_W;

   // CORDIC datapath width: Q2.30 values with headroom.
   localparam int CORDIC_W = 34;

   // Phase units per radian, where 2^32 phase units make one turn.
   localparam logic [29:0] PHASE_PER_RAD = 30'd683565276;

   // CORDIC start value: the inverse gain in Q2.30.
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // A quarter turn in phase units.
   localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 34'sd1073741824;

   typedef enum logic [1:0] {
      CMD_UPDATE = 2'd0,
      CMD_INIT   = 2'd1,
      CMD_SET    = 2'd2
   } ego_cmd_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MDX,
      S_MDY,
      S_MPH,
      S_CSTART,
      S_ROT,
      S_MXC,
      S_MYS,
      S_MXS,
      S_MYC,
      S_ACCY,
      S_DONE
   } ego_state_type;

   typedef struct packed {
      logic                       done;
      logic signed [MUL_OP_W-1:0] cos_val;
      logic signed [MUL_OP_W-1:0] sin_val;
   } ego_cordic_out_type;

   // Arctangent of 2^-i in phase units.
   function automatic logic [29:0] atan_phase(input logic [4:0] idx);
      logic [29:0] val;
      unique case (idx)
         5'd0:  val = 30'd536870912;
         5'd1:  val = 30'd316933406;
         5'd2:  val = 30'd167458907;
         5'd3:  val = 30'd85004756;
         5'd4:  val = 30'd42667331;
         5'd5:  val = 30'd21354465;
         5'd6:  val = 30'd10679838;
         5'd7:  val = 30'd5340245;
         5'd8:  val = 30'd2670163;
         5'd9:  val = 30'd1335087;
         5'd10: val = 30'd667544;
         5'd11: val = 30'd333772;
         5'd12: val = 30'd166886;
         5'd13: val = 30'd83443;
         5'd14: val = 30'd41722;
         5'd15: val = 30'd20861;
         5'd16: val = 30'd10430;
         5'd17: val = 30'd5215;
         5'd18: val = 30'd2608;
         5'd19: val = 30'd1304;
         5'd20: val = 30'd652;
         5'd21: val = 30'd326;
         5'd22: val = 30'd163;
         5'd23: val = 30'd81;
         5'd24: val = 30'd41;
         5'd25: val = 30'd20;
         5'd26: val = 30'd10;
         5'd27: val = 30'd5;
         5'd28: val = 30'd3;
         5'd29: val = 30'd1;
         5'd30: val = 30'd1;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

FILE: design/ego_req_if.sv
interface ego_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [31:0] count_x;
   logic signed [31:0] count_y;
   logic signed [31:0] gyro_heading;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic signed [31:0] new_heading;

   modport source (
      output valid, command, count_x, count_y, gyro_heading, new_x, new_y, new_heading,
      input  ready
   );
   modport sink (
      input  valid, command, count_x, count_y, gyro_heading, new_x, new_y, new_heading,
      output ready
   );
endinterface

FILE: design/ego_rsp_if.sv
interface ego_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic signed [31:0] pose_heading;
   logic               initialized;

   modport source (
      output valid, pose_x, pose_y, pose_heading, initialized,
      input  ready
   );
   modport sink (
      input  valid, pose_x, pose_y, pose_heading, initialized,
      output ready
   );
endinterface

FILE: design/ego_csr_if.sv
interface ego_csr_if;
   logic                             valid;
   logic                             ready;
   logic [ego_pkg::CSR_INDEX_W-1:0]  index;
   logic [31:0]                      data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

FILE: design/encoder_gyro_odometry_unit.sv
// Dead-reckoning pose tracker for two tracking-wheel encoders and a gyro. Each request
// beat carries a command: update folds the encoder count differences (scaled by the
// scale_x and scale_y registers, unsigned Q0.32 metres per count) and the gyro heading
// difference into the pose, rotating the local step by the new heading; init loads the
// pose, clears the stored samples and marks the tracker initialized; set loads the pose
// only. Updates before the first init, and the unused command code, leave the pose as it
// is. Every request gives exactly one response beat with the pose in Q16.16 and the
// initialized flag. An update takes its time in the iterative CORDIC, which does one
// micro-rotation per cycle after a start step and then reports done, and in seven
// passes through the one shared 33x33 multiplier. Other commands go straight from
// acceptance to the response step. The block is ready for the next request in the
// cycle its response beat appears. The response sits in an output register, so a new
// request is taken while the previous response still waits. Configuration beats are
// taken in every cycle and must only be sent while the block is idle.
module encoder_gyro_odometry_unit #(
   parameter int CORDIC_ITERATIONS = ego_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ego_req_if.sink   req_if,
   ego_rsp_if.source rsp_if,
   ego_csr_if.sink   csr_if
);

   ego_pkg::ego_state_type state_ff, state_in;

   // Configuration registers.
   logic [31:0] scale_x_ff, scale_x_in;
   logic [31:0] scale_y_ff, scale_y_in;

   // Architectural pose and sample state.
   logic [31:0] acc_x_ff, acc_x_in;
   logic [31:0] acc_y_ff, acc_y_in;
   logic [31:0] acc_h_ff, acc_h_in;
   logic [31:0] last_cx_ff, last_cx_in;
   logic [31:0] last_cy_ff, last_cy_in;
   logic [31:0] last_g_ff, last_g_in;
   logic        ready_flag_ff, ready_flag_in;

   // Working registers of one update.
   logic [31:0] cx_ff, cx_in;
   logic [31:0] cy_ff, cy_in;
   logic [31:0] g_ff, g_in;
   logic [31:0] dcx_ff, dcx_in;
   logic [31:0] dcy_ff, dcy_in;
   logic [31:0] heading_ff, heading_in;
   logic [31:0] dx_ff, dx_in;
   logic [31:0] dy_ff, dy_in;
   logic [63:0] t_ff, t_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_x_ff, rsp_x_in;
   logic [31:0] rsp_y_ff, rsp_y_in;
   logic [31:0] rsp_h_ff, rsp_h_in;
   logic        rsp_init_ff, rsp_init_in;

   // Shared multiplier and CORDIC hookup.
   logic signed [ego_pkg::MUL_OP_W-1:0]   mul_a;
   logic signed [ego_pkg::MUL_OP_W-1:0]   mul_b;
   logic signed [ego_pkg::MUL_PROD_W-1:0] prod;
   logic                                  cordic_start;
   ego_pkg::ego_cordic_out_type           cordic_res;

   ego_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // The phase comes straight from the product register in the cycle that starts
   // the rotation.
   ego_cordic #(
      .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
   ) u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .phase  (prod[47:16]),
      .result (cordic_res)
   );

   assign req_if.ready = (state_ff == ego_pkg::S_IDLE);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.pose_x       = rsp_x_ff;
   assign rsp_if.pose_y       = rsp_y_ff;
   assign rsp_if.pose_heading = rsp_h_ff;
   assign rsp_if.initialized  = rsp_init_ff;

   // Sequencer: next state, datapath updates and multiplier operand selection.
   always_comb begin
      logic [63:0] sum64;

      state_in      = state_ff;
      scale_x_in    = scale_x_ff;
      scale_y_in    = scale_y_ff;
      acc_x_in      = acc_x_ff;
      acc_y_in      = acc_y_ff;
      acc_h_in      = acc_h_ff;
      last_cx_in    = last_cx_ff;
      last_cy_in    = last_cy_ff;
      last_g_in     = last_g_ff;
      ready_flag_in = ready_flag_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      g_in          = g_ff;
      dcx_in        = dcx_ff;
      dcy_in        = dcy_ff;
      heading_in    = heading_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      t_in          = t_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_init_in   = rsp_init_ff;
      mul_a         = '0;
      mul_b         = '0;
      cordic_start  = 1'b0;
      sum64         = '0;

      // A waiting response leaves as soon as the sink takes it.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes; indexes past the list are dropped.
      if (csr_if.valid) begin
         if (csr_if.index == ego_pkg::REG_SCALE_X) begin
            scale_x_in = csr_if.data;
         end else if (csr_if.index == ego_pkg::REG_SCALE_Y) begin
            scale_y_in = csr_if.data;
         end
      end

      unique case (state_ff)
         ego_pkg::S_IDLE: begin
            if (req_if.valid) begin
               cx_in      = req_if.count_x;
               cy_in      = req_if.count_y;
               g_in       = req_if.gyro_heading;
               dcx_in     = req_if.count_x - last_cx_ff;
               dcy_in     = req_if.count_y - last_cy_ff;
               heading_in = acc_h_ff + (req_if.gyro_heading - last_g_ff);
               if (req_if.command == ego_pkg::CMD_UPDATE && ready_flag_ff) begin
                  state_in = ego_pkg::S_MDX;
               end else begin
                  // Pose loads complete right here; anything else returns the pose.
                  if (req_if.command == ego_pkg::CMD_INIT ||
                      req_if.command == ego_pkg::CMD_SET) begin
                     acc_x_in = req_if.new_x;
                     acc_y_in = req_if.new_y;
                     acc_h_in = req_if.new_heading;
                  end
                  if (req_if.command == ego_pkg::CMD_INIT) begin
                     last_cx_in    = '0;
                     last_cy_in    = '0;
                     last_g_in     = '0;
                     ready_flag_in = 1'b1;
                  end
                  state_in = ego_pkg::S_DONE;
               end
            end
         end
         ego_pkg::S_MDX: begin
            mul_a    = {dcx_ff[31], dcx_ff};
            mul_b    = {1'b0, scale_x_ff};
            state_in = ego_pkg::S_MDY;
         end
         ego_pkg::S_MDY: begin
            dx_in    = prod[47:16];
            mul_a    = {dcy_ff[31], dcy_ff};
            mul_b    = {1'b0, scale_y_ff};
            state_in = ego_pkg::S_MPH;
         end
         ego_pkg::S_MPH: begin
            // Heading in radians to phase units.
            dy_in    = prod[47:16];
            mul_a    = {heading_ff[31], heading_ff};
            mul_b    = {3'b0, ego_pkg::PHASE_PER_RAD};
            state_in = ego_pkg::S_CSTART;
         end
         ego_pkg::S_CSTART: begin
            cordic_start = 1'b1;
            state_in     = ego_pkg::S_ROT;
         end
         ego_pkg::S_ROT: begin
            if (cordic_res.done) begin
               state_in = ego_pkg::S_MXC;
            end
         end
         ego_pkg::S_MXC: begin
            mul_a    = {dx_ff[31], dx_ff};
            mul_b    = cordic_res.cos_val;
            state_in = ego_pkg::S_MYS;
         end
         ego_pkg::S_MYS: begin
            t_in     = prod[63:0];
            mul_a    = {dy_ff[31], dy_ff};
            mul_b    = cordic_res.sin_val;
            state_in = ego_pkg::S_MXS;
         end
         ego_pkg::S_MXS: begin
            // Global x step: (dx*cos - dy*sin) scaled back to Q16.16, floored.
            sum64    = t_ff - prod[63:0];
            acc_x_in = acc_x_ff + sum64[61:30];
            mul_a    = {dx_ff[31], dx_ff};
            mul_b    = cordic_res.sin_val;
            state_in = ego_pkg::S_MYC;
         end
         ego_pkg::S_MYC: begin
            t_in     = prod[63:0];
            mul_a    = {dy_ff[31], dy_ff};
            mul_b    = cordic_res.cos_val;
            state_in = ego_pkg::S_ACCY;
         end
         ego_pkg::S_ACCY: begin
            // Global y step, then commit heading and samples.
            sum64      = t_ff + prod[63:0];
            acc_y_in   = acc_y_ff + sum64[61:30];
            acc_h_in   = heading_ff;
            last_cx_in = cx_ff;
            last_cy_in = cy_ff;
            last_g_in  = g_ff;
            state_in   = ego_pkg::S_DONE;
         end
         ego_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = acc_x_ff;
               rsp_y_in     = acc_y_ff;
               rsp_h_in     = acc_h_ff;
               rsp_init_in  = ready_flag_ff;
               state_in     = ego_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ego_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ego_pkg::S_IDLE;
         scale_x_ff    <= '0;
         scale_y_ff    <= '0;
         acc_x_ff      <= '0;
         acc_y_ff      <= '0;
         acc_h_ff      <= '0;
         last_cx_ff    <= '0;
         last_cy_ff    <= '0;
         last_g_ff     <= '0;
         ready_flag_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scale_x_ff    <= scale_x_in;
         scale_y_ff    <= scale_y_in;
         acc_x_ff      <= acc_x_in;
         acc_y_ff      <= acc_y_in;
         acc_h_ff      <= acc_h_in;
         last_cx_ff    <= last_cx_in;
         last_cy_ff    <= last_cy_in;
         last_g_ff     <= last_g_in;
         ready_flag_ff <= ready_flag_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      g_ff        <= g_in;
      dcx_ff      <= dcx_in;
      dcy_ff      <= dcy_in;
      heading_ff  <= heading_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      t_ff        <= t_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_h_ff    <= rsp_h_in;
      rsp_init_ff <= rsp_init_in;
   end

endmodule

FILE: design/ego_mul.sv
module ego_mul (
   input  logic                                   clock,
   input  logic signed [ego_pkg::MUL_OP_W-1:0]    op_a,
   input  logic signed [ego_pkg::MUL_OP_W-1:0]    op_b,
   output logic signed [ego_pkg::MUL_PROD_W-1:0]  prod_ff
);

   logic signed [ego_pkg::MUL_PROD_W-1:0] prod_in;

   // The product is registered so the next step starts from a clean flop.
   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: design/ego_cordic.sv
module ego_cordic #(
   parameter int CORDIC_ITERATIONS = ego_pkg::CORDIC_ITERATIONS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 phase,
   output ego_pkg::ego_cordic_out_type result
);

   localparam int CW = $clog2(CORDIC_ITERATIONS);
   localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_ITERATIONS - 1);

   logic signed [ego_pkg::CORDIC_W-1:0] x_ff, x_in;
   logic signed [ego_pkg::CORDIC_W-1:0] y_ff, y_in;
   logic signed [ego_pkg::CORDIC_W-1:0] z_ff, z_in;
   logic [CW-1:0]                       cnt_ff, cnt_in;
   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic                                flip_ff, flip_in;

   always_comb begin
      logic signed [ego_pkg::CORDIC_W-1:0] z_start;
      logic signed [ego_pkg::CORDIC_W-1:0] xs;
      logic signed [ego_pkg::CORDIC_W-1:0] ys;
      logic signed [ego_pkg::CORDIC_W-1:0] angle;
      logic                                flip_start;

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      flip_in = flip_ff;

      // Fold the phase into the right half plane; the outputs are negated later.
      z_start    = {{2{phase[31]}}, phase};
      flip_start = 1'b0;
      if (z_start > ego_pkg::QUARTER_TURN || z_start < -ego_pkg::QUARTER_TURN) begin
         z_start    = {{2{~phase[31]}}, ~phase[31], phase[30:0]};
         flip_start = 1'b1;
      end

      xs    = x_ff >>> cnt_ff;
      ys    = y_ff >>> cnt_ff;
      angle = signed'({4'b0, ego_pkg::atan_phase(5'(cnt_ff))});

      priority if (start) begin
         x_in    = ego_pkg::CORDIC_GAIN;
         y_in    = '0;
         z_in    = z_start;
         flip_in = flip_start;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - angle;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + angle;
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else begin
         // Idle: the last rotation result is held.
         done_in = done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign result.done    = done_ff;
   assign result.cos_val = ego_pkg::MUL_OP_W'(flip_ff ? -x_ff : x_ff);
   assign result.sin_val = ego_pkg::MUL_OP_W'(flip_ff ? -y_ff : y_ff);

endmodule
